@@ rtl/uvto_pkg.sv @@
// ----------------------------------------------------------------------------
// uvto_pkg: shared widths and types for the triangle overlap pipeline.
// Coordinates are 18-bit signed; all geometry is exact integer arithmetic.
// ----------------------------------------------------------------------------
package uvto_pkg;

    localparam int COORD_W      = 18;
    localparam int MARGIN_W     = 10;
    localparam int MARGIN_SHIFT = 20;
    // The answer compares only signs and ratios of areas, so it does not
    // depend on the fraction width.
    localparam int COORD_FRAC_BITS = 16;
    // Differences of coordinates, with the centroid scaled by 3.
    localparam int DIFF_W  = COORD_W + 4;
    // Products and cross terms of differences.
    localparam int CROSS_W = 2 * DIFF_W + 1;
    // Absolute area times the margin.
    localparam int MPROD_W = CROSS_W + MARGIN_W + 1;
    // Area times margin, or weight times 2^20.
    localparam int LIM_W   = CROSS_W + MARGIN_SHIFT + 1;

    typedef logic signed [COORD_W-1:0]  coord_t;
    typedef logic signed [DIFF_W-1:0]   diff_t;
    typedef logic signed [DIFF_W:0]     sub_t;
    typedef logic signed [2*DIFF_W+1:0] prod_t;
    typedef logic signed [CROSS_W-1:0]  cross_t;
    typedef logic signed [MPROD_W-1:0]  mprod_t;
    typedef logic signed [LIM_W-1:0]    lim_t;

    // One point, scaled by 3 where it is used for containment tests.
    typedef struct packed {
        diff_t x;
        diff_t y;
    } pt_t;

    typedef struct packed {
        pt_t a;
        pt_t b;
        pt_t c;
    } tri_t;

    // Twice the signed area of (p, q, r), one multiplier layer.
    function automatic cross_t cross3(input pt_t p, input pt_t q, input pt_t r);
        sub_t  dqx;
        sub_t  dqy;
        sub_t  drx;
        sub_t  dry;
        prod_t t1;
        prod_t t2;
        begin
            dqx = sub_t'(q.x) - sub_t'(p.x);
            dqy = sub_t'(q.y) - sub_t'(p.y);
            drx = sub_t'(r.x) - sub_t'(p.x);
            dry = sub_t'(r.y) - sub_t'(p.y);
            t1 = dqx * dry;
            t2 = drx * dqy;
            cross3 = cross_t'(t1 - t2);
        end
    endfunction

endpackage

@@ rtl/uv_triangle_overlap_test.sv @@
// ----------------------------------------------------------------------------
// uv_triangle_overlap_test: two-triangle interior overlap, fully pipelined.
//
//   channel  | handshake           | payload
//   ---------+---------------------+----------------------------------
//   input    | in_valid / in_stall | first_*, second_* (18-bit signed)
//   output   | out_valid/out_stall | overlap
//   config   | cfg_we              | cfg_data (edge_margin, 10 bits)
//
// One request is taken every cycle while in_stall is low. The depth is set
// by the four register stages: bounds and scaling, cross products, margin
// scaling, compare and reduce. Reset empties the pipeline and sets the
// margin to 10. A stall holds each full stage with no gap after it; gaps still fill.
// ----------------------------------------------------------------------------
module uv_triangle_overlap_test (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [uvto_pkg::MARGIN_W-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  uvto_pkg::coord_t              first_ax,
    input  uvto_pkg::coord_t              first_ay,
    input  uvto_pkg::coord_t              first_bx,
    input  uvto_pkg::coord_t              first_by,
    input  uvto_pkg::coord_t              first_cx,
    input  uvto_pkg::coord_t              first_cy,
    input  uvto_pkg::coord_t              second_ax,
    input  uvto_pkg::coord_t              second_ay,
    input  uvto_pkg::coord_t              second_bx,
    input  uvto_pkg::coord_t              second_by,
    input  uvto_pkg::coord_t              second_cx,
    input  uvto_pkg::coord_t              second_cy,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          overlap
);

    localparam int DEPTH = 4;

    logic [uvto_pkg::MARGIN_W-1:0] margin_reg;
    logic [DEPTH-1:0]              en;
    logic [DEPTH-1:0]              vld;
    uvto_pkg::coord_t              fc [6];
    uvto_pkg::coord_t              sc [6];
    logic                          ov;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_reg <= uvto_pkg::MARGIN_W'(10);
        end
        else if (cfg_we)
        begin
            margin_reg <= cfg_data;
        end
    end

    assign fc[0] = first_ax;
    assign fc[1] = first_ay;
    assign fc[2] = first_bx;
    assign fc[3] = first_by;
    assign fc[4] = first_cx;
    assign fc[5] = first_cy;
    assign sc[0] = second_ax;
    assign sc[1] = second_ay;
    assign sc[2] = second_bx;
    assign sc[3] = second_by;
    assign sc[4] = second_cx;
    assign sc[5] = second_cy;

    uvto_pipe_ctl #(.DEPTH(DEPTH)) u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .en        (en),
        .vld       (vld),
        .in_stall  (in_stall)
    );

    uvto_geom u_geom (
        .clk     (clk),
        .en      (en),
        .margin  (margin_reg),
        .fc      (fc),
        .sc      (sc),
        .overlap (ov)
    );

    assign out_valid = vld[DEPTH-1];
    assign overlap   = ov;

endmodule

@@ rtl/uvto_pipe_ctl.sv @@
// ----------------------------------------------------------------------------
// uvto_pipe_ctl: valid and enable control of a stalling pipeline.
// A stage advances when it is empty or when the stage after it advances.
// ----------------------------------------------------------------------------
module uvto_pipe_ctl #(
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             out_stall,
    output logic [DEPTH-1:0] en,
    output logic [DEPTH-1:0] vld,
    output logic             in_stall
);

    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] vld_next;

    always_comb
    begin
        en[DEPTH-1] = !vld_reg[DEPTH-1] || !out_stall;
        for (int i = DEPTH - 2; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (en[0])
        begin
            vld_next[0] = in_valid;
        end
        for (int i = 1; i < DEPTH; i++)
        begin
            if (en[i])
            begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign vld      = vld_reg;
    assign in_stall = !en[0];

endmodule

@@ rtl/uvto_geom.sv @@
// ----------------------------------------------------------------------------
// uvto_geom: the arithmetic stages. Stage 1 scales points and compares boxes,
// stage 2 forms all cross products, stage 3 multiplies by the margin and
// 2^20, stage 4 compares and reduces to one overlap flag.
// ----------------------------------------------------------------------------
module uvto_geom (
    input  logic                          clk,
    input  logic [3:0]                    en,
    input  logic [uvto_pkg::MARGIN_W-1:0] margin,
    input  uvto_pkg::coord_t              fc [6],
    input  uvto_pkg::coord_t              sc [6],
    output logic                          overlap
);

    localparam int NPT = 8; // centroid + 3 corners, per triangle tested

    // ---------------- stage 1 ----------------
    uvto_pkg::tri_t f_reg, s_reg;     // unscaled, for edge tests
    uvto_pkg::tri_t f3_reg, s3_reg;   // scaled by 3
    uvto_pkg::pt_t  fcen_reg, scen_reg;
    logic           box_ok_reg;

    uvto_pkg::tri_t f_next, s_next, f3_next, s3_next;
    uvto_pkg::pt_t  fcen_next, scen_next;
    logic           box_ok_next;

    function automatic uvto_pkg::pt_t mkpt(input uvto_pkg::coord_t x,
                                           input uvto_pkg::coord_t y);
        uvto_pkg::pt_t p;
        begin
            p.x = uvto_pkg::diff_t'(x);
            p.y = uvto_pkg::diff_t'(y);
            mkpt = p;
        end
    endfunction

    function automatic uvto_pkg::pt_t pt3(input uvto_pkg::pt_t p);
        uvto_pkg::pt_t r;
        begin
            r.x = uvto_pkg::diff_t'(p.x * 3);
            r.y = uvto_pkg::diff_t'(p.y * 3);
            pt3 = r;
        end
    endfunction

    function automatic logic signed [uvto_pkg::COORD_W-1:0] mn3(
        input uvto_pkg::coord_t a, input uvto_pkg::coord_t b, input uvto_pkg::coord_t c);
        logic signed [uvto_pkg::COORD_W-1:0] m;
        begin
            m = (a < b) ? a : b;
            mn3 = (c < m) ? c : m;
        end
    endfunction

    function automatic logic signed [uvto_pkg::COORD_W-1:0] mx3(
        input uvto_pkg::coord_t a, input uvto_pkg::coord_t b, input uvto_pkg::coord_t c);
        logic signed [uvto_pkg::COORD_W-1:0] m;
        begin
            m = (a > b) ? a : b;
            mx3 = (c > m) ? c : m;
        end
    endfunction

    always_comb
    begin
        f_next.a = mkpt(fc[0], fc[1]);
        f_next.b = mkpt(fc[2], fc[3]);
        f_next.c = mkpt(fc[4], fc[5]);
        s_next.a = mkpt(sc[0], sc[1]);
        s_next.b = mkpt(sc[2], sc[3]);
        s_next.c = mkpt(sc[4], sc[5]);
        f3_next.a = pt3(f_next.a);
        f3_next.b = pt3(f_next.b);
        f3_next.c = pt3(f_next.c);
        s3_next.a = pt3(s_next.a);
        s3_next.b = pt3(s_next.b);
        s3_next.c = pt3(s_next.c);
        fcen_next.x = f_next.a.x + f_next.b.x + f_next.c.x;
        fcen_next.y = f_next.a.y + f_next.b.y + f_next.c.y;
        scen_next.x = s_next.a.x + s_next.b.x + s_next.c.x;
        scen_next.y = s_next.a.y + s_next.b.y + s_next.c.y;
        box_ok_next = (mx3(fc[0], fc[2], fc[4]) > mn3(sc[0], sc[2], sc[4]))
                   && (mx3(sc[0], sc[2], sc[4]) > mn3(fc[0], fc[2], fc[4]))
                   && (mx3(fc[1], fc[3], fc[5]) > mn3(sc[1], sc[3], sc[5]))
                   && (mx3(sc[1], sc[3], sc[5]) > mn3(fc[1], fc[3], fc[5]));
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            f_reg      <= f_next;
            s_reg      <= s_next;
            f3_reg     <= f3_next;
            s3_reg     <= s3_next;
            fcen_reg   <= fcen_next;
            scen_reg   <= scen_next;
            box_ok_reg <= box_ok_next;
        end
    end

    // ---------------- stage 2: cross products ----------------
    // Containment tests: points 0..3 (centroid of first, first corners) tested
    // against the second triangle; points 4..7 against the first.
    uvto_pkg::cross_t area_reg [2];
    uvto_pkg::cross_t w_reg [NPT][3];
    logic [8:0]       cross_reg;
    logic             box2_reg;

    uvto_pkg::cross_t area_next [2];
    uvto_pkg::cross_t w_next [NPT][3];
    logic [8:0]       cross_next;
    uvto_pkg::pt_t    pts [NPT];
    uvto_pkg::pt_t    fe [3];
    uvto_pkg::pt_t    se [3];

    function automatic logic [1:0] sgn(input uvto_pkg::cross_t c);
        begin
            sgn = {c < 0, c > 0};
        end
    endfunction

    always_comb
    begin
        pts[0] = fcen_reg;
        pts[1] = f3_reg.a;
        pts[2] = f3_reg.b;
        pts[3] = f3_reg.c;
        pts[4] = scen_reg;
        pts[5] = s3_reg.a;
        pts[6] = s3_reg.b;
        pts[7] = s3_reg.c;
        area_next[0] = uvto_pkg::cross3(s3_reg.a, s3_reg.b, s3_reg.c);
        area_next[1] = uvto_pkg::cross3(f3_reg.a, f3_reg.b, f3_reg.c);
        for (int i = 0; i < NPT; i++)
        begin
            if (i < 4)
            begin
                w_next[i][0] = uvto_pkg::cross3(pts[i], s3_reg.b, s3_reg.c);
                w_next[i][1] = uvto_pkg::cross3(s3_reg.a, pts[i], s3_reg.c);
                w_next[i][2] = uvto_pkg::cross3(s3_reg.a, s3_reg.b, pts[i]);
            end
            else
            begin
                w_next[i][0] = uvto_pkg::cross3(pts[i], f3_reg.b, f3_reg.c);
                w_next[i][1] = uvto_pkg::cross3(f3_reg.a, pts[i], f3_reg.c);
                w_next[i][2] = uvto_pkg::cross3(f3_reg.a, f3_reg.b, pts[i]);
            end
        end
        fe[0] = f_reg.a;
        fe[1] = f_reg.b;
        fe[2] = f_reg.c;
        se[0] = s_reg.a;
        se[1] = s_reg.b;
        se[2] = s_reg.c;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                logic [1:0] d1, d2, d3, d4;
                d1 = sgn(uvto_pkg::cross3(fe[i], fe[(i+1)%3], se[j]));
                d2 = sgn(uvto_pkg::cross3(fe[i], fe[(i+1)%3], se[(j+1)%3]));
                d3 = sgn(uvto_pkg::cross3(se[j], se[(j+1)%3], fe[i]));
                d4 = sgn(uvto_pkg::cross3(se[j], se[(j+1)%3], fe[(i+1)%3]));
                // Proper crossing: both pairs of side signs nonzero and opposite.
                cross_next[i*3+j] = ((d1 == 2'b01 && d2 == 2'b10) || (d1 == 2'b10 && d2 == 2'b01))
                                 && ((d3 == 2'b01 && d4 == 2'b10) || (d3 == 2'b10 && d4 == 2'b01));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            area_reg  <= area_next;
            w_reg     <= w_next;
            cross_reg <= cross_next;
            box2_reg  <= box_ok_reg;
        end
    end

    // ---------------- stage 3: sign fold and scaling ----------------
    uvto_pkg::lim_t lim_reg [2];
    uvto_pkg::lim_t ws_reg [NPT][3];
    logic [1:0]     nz_reg;
    logic           hit3_reg;
    logic           box3_reg;

    uvto_pkg::lim_t lim_next [2];
    uvto_pkg::lim_t ws_next [NPT][3];
    logic [1:0]     nz_next;

    always_comb
    begin
        for (int t = 0; t < 2; t++)
        begin
            uvto_pkg::cross_t aa;
            uvto_pkg::mprod_t mp;
            aa = area_reg[t] < 0 ? -area_reg[t] : area_reg[t];
            mp = aa * $signed({1'b0, margin});
            nz_next[t]  = area_reg[t] != 0;
            lim_next[t] = uvto_pkg::lim_t'(mp);
        end
        for (int i = 0; i < NPT; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                uvto_pkg::lim_t wv;
                wv = uvto_pkg::lim_t'(w_reg[i][k]);
                if (area_reg[i/4] < 0)
                begin
                    wv = -wv;
                end
                ws_next[i][k] = wv <<< uvto_pkg::MARGIN_SHIFT;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            lim_reg  <= lim_next;
            ws_reg   <= ws_next;
            nz_reg   <= nz_next;
            hit3_reg <= |cross_reg;
            box3_reg <= box2_reg;
        end
    end

    // ---------------- stage 4: compares and reduction ----------------
    logic ov_reg;
    logic ov_next;

    always_comb
    begin
        ov_next = hit3_reg;
        for (int i = 0; i < NPT; i++)
        begin
            if (nz_reg[i/4] && ws_reg[i][0] > lim_reg[i/4] && ws_reg[i][1] > lim_reg[i/4]
                && ws_reg[i][2] > lim_reg[i/4])
            begin
                ov_next = 1'b1;
            end
        end
        ov_next = ov_next && box3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            ov_reg <= ov_next;
        end
    end

    assign overlap = ov_reg;

endmodule

@@ rtl/uvto_checker.sv @@
// ----------------------------------------------------------------------------
// uvto_checker: port-level checks of the overlap pipeline.
// ----------------------------------------------------------------------------
module uvto_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic overlap
);

    // A held result keeps its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(overlap))
        else $error("held result changed");

    // With the output free, the input is never stalled.
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while output free");

    // A request accepted into a free pipe is offered once it has passed all stages, if the output stays free.
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall
        |=> out_valid)
        else $error("result missing after four cycles");

    // The input stalls only if a result is waiting.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("stall without waiting result");

endmodule

bind uv_triangle_overlap_test uvto_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .overlap   (overlap)
);

@@ bench/uv_triangle_overlap_test_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle overlap testbench
// Drives triangle pairs through the valid/stall input channel with random
// gaps, predicts each overlap answer with exact integer geometry, and checks
// the answers in order while the output side stalls at random. The margin
// register is swept over several values between phases.
// ----------------------------------------------------------------------------
module uv_triangle_overlap_test_tb;

    typedef struct {
        uvto_pkg::coord_t c [12];
    } pair_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [uvto_pkg::MARGIN_W-1:0] cfg_data;
    logic                          in_valid;
    logic                          in_stall;
    uvto_pkg::coord_t              crd [12];
    logic                          out_valid;
    logic                          out_stall;
    logic                          overlap;

    pair_t               pending_pairs [$];
    logic                expected_overlap [$];
    int unsigned         margin_model;
    int unsigned         error_count = 0;
    int unsigned         idle_pct;

    uv_triangle_overlap_test u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .first_ax  (crd[0]),
        .first_ay  (crd[1]),
        .first_bx  (crd[2]),
        .first_by  (crd[3]),
        .first_cx  (crd[4]),
        .first_cy  (crd[5]),
        .second_ax (crd[6]),
        .second_ay (crd[7]),
        .second_bx (crd[8]),
        .second_by (crd[9]),
        .second_cx (crd[10]),
        .second_cy (crd[11]),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .overlap   (overlap)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint area2(longint px, longint py, longint qx, longint qy,
                                     longint rx, longint ry);
        return (qx - px) * (ry - py) - (rx - px) * (qy - py);
    endfunction

    // t holds three vertices scaled by 3; (px, py) is scaled the same way.
    function automatic bit point_strictly_in(longint t [6], longint px, longint py);
        longint a;
        longint u;
        longint v;
        longint w;
        longint lim;
        a = area2(t[0], t[1], t[2], t[3], t[4], t[5]);
        u = area2(px, py, t[2], t[3], t[4], t[5]);
        v = area2(t[0], t[1], px, py, t[4], t[5]);
        w = area2(t[0], t[1], t[2], t[3], px, py);
        if (a == 0)
            return 1'b0;
        if (a < 0)
        begin
            a = -a;
            u = -u;
            v = -v;
            w = -w;
        end
        lim = longint'(margin_model) * a;
        return (u * 64'sd1048576 > lim) && (v * 64'sd1048576 > lim)
            && (w * 64'sd1048576 > lim);
    endfunction

    function automatic int sgn(longint x);
        return x > 0 ? 1 : (x < 0 ? -1 : 0);
    endfunction

    function automatic bit predict_overlap(pair_t p);
        longint f [6];
        longint s [6];
        longint f3 [6];
        longint s3 [6];
        longint flo;
        longint fhi;
        longint slo;
        longint shi;
        longint fcx;
        longint fcy;
        longint scx;
        longint scy;
        int d1;
        int d2;
        int d3;
        int d4;
        int i2;
        int j2;
        for (int k = 0; k < 6; k++)
        begin
            f[k] = p.c[k];
            s[k] = p.c[6 + k];
            f3[k] = 3 * f[k];
            s3[k] = 3 * s[k];
        end
        for (int k = 0; k < 2; k++)
        begin
            flo = f[k];
            fhi = f[k];
            slo = s[k];
            shi = s[k];
            for (int i = 1; i < 3; i++)
            begin
                if (f[2*i+k] < flo) flo = f[2*i+k];
                if (f[2*i+k] > fhi) fhi = f[2*i+k];
                if (s[2*i+k] < slo) slo = s[2*i+k];
                if (s[2*i+k] > shi) shi = s[2*i+k];
            end
            if (fhi <= slo || shi <= flo)
                return 1'b0;
        end
        fcx = f[0] + f[2] + f[4];
        fcy = f[1] + f[3] + f[5];
        scx = s[0] + s[2] + s[4];
        scy = s[1] + s[3] + s[5];
        if (point_strictly_in(s3, fcx, fcy) || point_strictly_in(f3, scx, scy))
            return 1'b1;
        for (int i = 0; i < 3; i++)
            if (point_strictly_in(s3, f3[2*i], f3[2*i+1])
                || point_strictly_in(f3, s3[2*i], s3[2*i+1]))
                return 1'b1;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                i2 = (i + 1) % 3;
                j2 = (j + 1) % 3;
                d1 = sgn(area2(f[2*i], f[2*i+1], f[2*i2], f[2*i2+1], s[2*j], s[2*j+1]));
                d2 = sgn(area2(f[2*i], f[2*i+1], f[2*i2], f[2*i2+1], s[2*j2], s[2*j2+1]));
                d3 = sgn(area2(s[2*j], s[2*j+1], s[2*j2], s[2*j2+1], f[2*i], f[2*i+1]));
                d4 = sgn(area2(s[2*j], s[2*j+1], s[2*j2], s[2*j2+1], f[2*i2], f[2*i2+1]));
                if (d1 * d2 < 0 && d3 * d4 < 0)
                    return 1'b1;
            end
        return 1'b0;
    endfunction

    function automatic pair_t make_pair(
        uvto_pkg::coord_t x0, uvto_pkg::coord_t y0, uvto_pkg::coord_t x1,
        uvto_pkg::coord_t y1, uvto_pkg::coord_t x2, uvto_pkg::coord_t y2,
        uvto_pkg::coord_t x3, uvto_pkg::coord_t y3, uvto_pkg::coord_t x4,
        uvto_pkg::coord_t y4, uvto_pkg::coord_t x5, uvto_pkg::coord_t y5);
        pair_t p;
        p.c = '{x0, y0, x1, y1, x2, y2, x3, y3, x4, y4, x5, y5};
        return p;
    endfunction

    // Appends one request to the stimulus queue.
    function automatic void add_pair(pair_t p);
        pending_pairs = {pending_pairs, p};
    endfunction

    // Random pair: mostly nearby triangles of varied scale so that every branch
    // of the test is reached; some fully random and some degenerate.
    function automatic pair_t random_pair();
        pair_t p;
        int span;
        int cx;
        int cy;
        int kind;
        kind = $urandom_range(0, 99);
        span = 1 << $urandom_range(1, 17);
        cx = $signed($urandom_range(0, 262143)) - 131072;
        cy = $signed($urandom_range(0, 262143)) - 131072;
        for (int k = 0; k < 12; k++)
        begin
            if (kind < 10)
                p.c[k] = uvto_pkg::coord_t'($urandom);
            else
                p.c[k] = uvto_pkg::coord_t'(((k % 2) ? cy : cx)
                         + $signed($urandom_range(0, span)) - span / 2);
        end
        if (kind >= 90)
        begin
            // Collinear first triangle or shared corner.
            p.c[4] = p.c[0];
            p.c[5] = p.c[1];
            if (kind >= 95)
            begin
                p.c[6] = p.c[2];
                p.c[7] = p.c[3];
            end
        end
        return p;
    endfunction

    // Driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            for (int k = 0; k < 12; k++)
                crd[k] <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (pending_pairs.size() != 0 && ($urandom_range(0, 99) >= idle_pct))
            begin
                in_valid <= 1'b1;
                for (int k = 0; k < 12; k++)
                    crd[k] <= pending_pairs[0].c[k];
                expected_overlap = {expected_overlap, predict_overlap(pending_pairs[0])};
                void'(pending_pairs.pop_front());
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor and output stall.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_overlap.size() == 0)
                begin
                    $error("unexpected result: overlap actual %0b", overlap);
                    error_count++;
                end
                else
                begin
                    if (overlap !== expected_overlap[0])
                    begin
                        $error("overlap mismatch: expected %0b actual %0b",
                               expected_overlap[0], overlap);
                        error_count++;
                    end
                    void'(expected_overlap.pop_front());
                end
            end
            out_stall <= ($urandom_range(0, 99) < idle_pct);
        end
    end

    task automatic drain_and_settle();
        while (pending_pairs.size() != 0 || expected_overlap.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_margin(int unsigned m);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= m[uvto_pkg::MARGIN_W-1:0];
        @(posedge clk);
        cfg_we   <= 1'b0;
        margin_model = m;
    endtask

    initial
    begin
        int unsigned margins [6];
        margins = '{0, 1023, 1, 512, 10, 333};
        margin_model = 10;
        idle_pct     = 21;
        rst_n    = 1'b0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests at the reset margin.
        add_pair(make_pair(0, 0, 65536, 0, 0, 65536,
                           16384, 16384, 80000, 16384, 16384, 80000));
        // Touching boxes.
        add_pair(make_pair(0, 0, 100, 0, 0, 100, 100, 0, 200, 0, 100, 100));
        // Far apart.
        add_pair(make_pair(-131072, -131072, -131000, -131072, -131072, -131000,
                           131071, 131071, 131000, 131071, 131071, 131000));
        // Extremes: big triangles covering the whole range.
        add_pair(make_pair(-131072, -131072, 131071, -131072, -131072, 131071,
                           131071, 131071, -131072, 131071, 131071, -131072));
        add_pair(make_pair(-131072, -131072, 131071, -131072, 0, 131071,
                           -1000, -1000, 1000, -1000, 0, 1000));
        // Zero-area first triangle crossing the second.
        add_pair(make_pair(-500, 0, 500, 0, 0, 0, 0, -300, 300, 300, -300, 300));
        // Zero-area both, crossing segments (edge test only).
        add_pair(make_pair(-500, -500, 500, 500, 0, 0,
                           -500, 500, 500, -500, 0, 0));
        // Star of David: edges cross, centroids shared.
        add_pair(make_pair(0, 600, -520, -300, 520, -300,
                           0, -600, 520, 300, -520, 300));
        // Collinear overlapping edges only.
        add_pair(make_pair(0, 0, 100, 0, 0, 100, 50, 0, 150, 0, 50, -100));
        // Clockwise orientation, small contained.
        add_pair(make_pair(0, 0, 0, 1000, 1000, 0, 100, 100, 100, 110, 110, 100));
        // Alternating bit patterns.
        add_pair(make_pair(-87382, 87381, 87381, -87382, -87382, -87382,
                           87381, 87381, -87382, 87381, 87381, -87382));
        add_pair(make_pair(-1, -1, 0, 0, -1, 0, 0, -1, -1, 0, 0, 0));
        drain_and_settle();

        for (int ph = 0; ph < 6; ph++)
        begin
            set_margin(margins[ph]);
            // One phase runs without idling on either side.
            idle_pct = (ph == 2) ? 0 : 21;
            for (int n = 0; n < 300; n++)
                add_pair(random_pair());
            // A few directed repeats under each margin.
            add_pair(make_pair(0, 0, 65536, 0, 0, 65536,
                               1, 1, 2, 1, 1, 2));
            add_pair(make_pair(0, 0, 1024, 0, 0, 1024,
                               10, 10, 20, 10, 10, 20));
            drain_and_settle();
        end

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
